### design/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

  // Sizing of the store and its fields.
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Width of the capacity register and its value after reset.
  localparam int CAP_BITS  = 5;
  localparam int CAP_RESET = 16;

  // Occupancy runs from zero to ENTRIES inclusive.
  localparam int OCC_BITS = $clog2(ENTRIES + 1);
  // Width at which capacity and occupancy are compared.
  localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

  // Request opcodes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // One stored entry as seen by the neighbouring cell.
  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic update;  // the chain moves in this cycle
    logic hit;     // the request key was found
    logic free;    // a miss inserts into an empty cell rather than evicting
  } ctrl_t;

endpackage

### design/lkv_cell.sv
`timescale 1ns / 1ps

module lkv_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  lkv_pkg::ctrl_t                 ctrl,
  input  lkv_pkg::entry_t                prev_entry,
  input  logic [lkv_pkg::KEY_BITS-1:0]   req_key,
  input  logic                           match_in,
  input  logic [lkv_pkg::VALUE_BITS-1:0] value_in,
  output lkv_pkg::entry_t                entry,
  output logic                           match_out,
  output logic [lkv_pkg::VALUE_BITS-1:0] value_out
);

  logic                           valid;
  logic [lkv_pkg::KEY_BITS-1:0]   stored_key;
  logic [lkv_pkg::VALUE_BITS-1:0] stored_value;
  logic                           own_match;
  logic                           shift;

  assign entry = '{valid: valid, key: stored_key, value: stored_value};

  // Compare against the request; the match and its value ripple towards cell 0.
  assign own_match = valid && (stored_key == req_key);
  assign match_out = own_match | match_in;
  assign value_out = own_match ? stored_value : value_in;

  // A cell takes its neighbour's entry when it lies in the region that ages.
  // On a hit that is every cell up to the matching one; on an insert every
  // cell up to the first empty one; on an eviction every occupied cell.
  always_comb begin
    if (ctrl.hit) begin
      shift = match_out;
    end else if (ctrl.free) begin
      shift = prev_entry.valid;
    end else begin
      shift = valid;
    end
  end

  // Valid mark, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.update && shift) begin
      valid <= prev_entry.valid;
    end
  end

  // Key and value follow the valid mark.
  always_ff @(posedge clk) begin
    if (ctrl.update && shift) begin
      stored_key   <= prev_entry.key;
      stored_value <= prev_entry.value;
    end
  end

endmodule

### design/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Requests: drive cmd (0 get, 1 put), key and write_value with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Results: done is registered from busy, so it rises after the working cycle
// of the request and is high for exactly one cycle; hit and read_value are
// valid in that cycle. read_value is the stored value on a get hit and zero
// otherwise. The receiver cannot hold a result off; it must take it in the
// cycle that done marks.
// No new request is taken while busy is high. The entries sit in a chain of
// cells ordered by recency; the whole compare, ripple and one-place shift
// of the chain happens in the cycle after the request is registered.
// Configuration: capacity is written through cfg_valid/cfg_ready while no
// request is in flight. Zero acts as one, values above the entry count act
// as the entry count.
// Reset (rst, synchronous): every entry becomes invalid, occupancy clears and
// capacity returns to the full entry count. No clearing pass is needed.
`timescale 1ns / 1ps

module lru_key_value_cache (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [lkv_pkg::KEY_BITS-1:0]   key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] write_value,
  output logic                           done,
  output logic                           hit,
  output logic [lkv_pkg::VALUE_BITS-1:0] read_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkv_pkg::CAP_BITS-1:0]   capacity
);

  logic                           req_cmd;
  logic [lkv_pkg::KEY_BITS-1:0]   req_key;
  logic [lkv_pkg::VALUE_BITS-1:0] req_value;
  logic [lkv_pkg::CAP_BITS-1:0]   cap_setting;
  logic [lkv_pkg::OCC_BITS-1:0]   occupancy;

  logic [lkv_pkg::CMP_BITS-1:0]   cap_wide;
  logic [lkv_pkg::CMP_BITS-1:0]   cap_eff;
  logic                           accept;
  logic                           is_put;
  logic                           found;
  lkv_pkg::ctrl_t                 ctrl;
  lkv_pkg::entry_t                new_entry;

  lkv_pkg::entry_t                cell_entry  [lkv_pkg::ENTRIES];
  logic [lkv_pkg::ENTRIES:0]      match_chain;
  logic [lkv_pkg::VALUE_BITS-1:0] value_chain [lkv_pkg::ENTRIES+1];
  logic [lkv_pkg::ENTRIES-1:0]    valid_vec;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign is_put    = (req_cmd == lkv_pkg::CMD_PUT);

  // Effective capacity: zero counts as one, large values saturate.
  assign cap_wide = lkv_pkg::CMP_BITS'(cap_setting);
  always_comb begin
    if (cap_wide == '0) begin
      cap_eff = lkv_pkg::CMP_BITS'(1);
    end else if (cap_wide > lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES)) begin
      cap_eff = lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES);
    end else begin
      cap_eff = cap_wide;
    end
  end

  // Chain ends: nothing matches beyond the last cell.
  assign match_chain[lkv_pkg::ENTRIES] = 1'b0;
  assign value_chain[lkv_pkg::ENTRIES] = '0;
  assign found = match_chain[0];

  // Control for the cells in the working cycle.
  assign ctrl.update = busy && (found || is_put);
  assign ctrl.hit    = found;
  assign ctrl.free   = lkv_pkg::CMP_BITS'(occupancy) < cap_eff;

  // The entry that becomes most recent enters at the head of the chain.
  assign new_entry = '{valid: 1'b1,
                       key:   req_key,
                       value: is_put ? req_value : value_chain[0]};

  // Row of cells, most recent first.
  for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
      .req_key    (req_key),
      .match_in   (match_chain[i+1]),
      .value_in   (value_chain[i+1]),
      .entry      (cell_entry[i]),
      .match_out  (match_chain[i]),
      .value_out  (value_chain[i])
    );
    assign valid_vec[i] = cell_entry[i].valid;
  end

  // Request registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= write_value;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (busy) begin
      hit        <= found;
      read_value <= (found && !is_put) ? value_chain[0] : '0;
    end
  end

  // Sequencing, capacity and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      cap_setting <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
      occupancy   <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (cfg_valid && cfg_ready) begin
        cap_setting <= capacity;
      end
      if (ctrl.update && !found && ctrl.free) begin
        occupancy <= occupancy + lkv_pkg::OCC_BITS'(1);
      end
    end
  end

  // A result always follows the working cycle of a request.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // The working cycle of a request is never directly followed by another.
  assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("request stayed in progress for more than one cycle");

  // The valid marks count exactly the occupancy.
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occupancy))
    else $error("valid marks disagree with occupancy");

  // Occupied cells form an unbroken run from the head of the chain.
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + lkv_pkg::ENTRIES'(1)) & valid_vec) == '0)
    else $error("gap in the recency chain");

  // A miss never returns data.
  assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (read_value == '0))
    else $error("data returned on a miss");

endmodule

### tb/lkv_checker.sv
`timescale 1ns / 1ps

// Watches the request, reply and capacity channels of the cache, keeps its own
// copy of the store and the recency order, and compares every reply with the
// value predicted for the oldest outstanding request.
module lkv_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           cmd,
  input  logic [lkv_pkg::KEY_BITS-1:0]   key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] write_value,
  input  logic                           done,
  input  logic                           hit,
  input  logic [lkv_pkg::VALUE_BITS-1:0] read_value,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lkv_pkg::CAP_BITS-1:0]   capacity,
  output int                             fail_count,
  output int                             pending
);

  localparam int RANK_BITS = (lkv_pkg::ENTRIES > 1) ? $clog2(lkv_pkg::ENTRIES) : 1;

  typedef struct packed {
    logic                           hit;
    logic [lkv_pkg::VALUE_BITS-1:0] read_value;
  } reply_t;

  // Replies predicted for requests that have been taken but not yet answered.
  reply_t expected_replies[$];

  // Shadow copy of the cache contents, recency order and capacity register.
  logic [lkv_pkg::KEY_BITS-1:0]   slot_key   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VALUE_BITS-1:0] slot_value [lkv_pkg::ENTRIES];
  logic                           slot_valid [lkv_pkg::ENTRIES];
  logic [RANK_BITS-1:0]           slot_rank  [lkv_pkg::ENTRIES];
  logic [lkv_pkg::OCC_BITS-1:0]   fill_level;
  logic [lkv_pkg::CAP_BITS-1:0]   cap_reg;
  int                             fails = 0;

  assign fail_count = fails;

  // Make slot s the most recent; every entry younger than it ages by one.
  task automatic promote(input int s);
    logic [RANK_BITS-1:0] old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < old_rank) begin
        slot_rank[i] = slot_rank[i] + 1'b1;
      end
    end
    slot_rank[s] = '0;
  endtask

  // Apply one get or put to the shadow store and work out its reply.
  task automatic serve_request(input logic is_put,
                               input logic [lkv_pkg::KEY_BITS-1:0] req_key,
                               input logic [lkv_pkg::VALUE_BITS-1:0] req_value,
                               output reply_t reply);
    int eff_cap;
    int found;
    int slot;
    int best;
    eff_cap = cap_reg;
    if (eff_cap == 0) eff_cap = 1;
    if (eff_cap > lkv_pkg::ENTRIES) eff_cap = lkv_pkg::ENTRIES;

    found = -1;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == req_key) found = i;
    end

    reply.hit        = (found >= 0);
    reply.read_value = '0;

    if (found >= 0) begin
      if (is_put == lkv_pkg::CMD_PUT) slot_value[found] = req_value;
      else reply.read_value = slot_value[found];
      promote(found);
    end else if (is_put == lkv_pkg::CMD_PUT) begin
      slot = -1;
      if (fill_level < eff_cap) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        // Free slot: everything already held ages by one.
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (slot_valid[i]) slot_rank[i] = slot_rank[i] + 1'b1;
        end
        slot_valid[slot] = 1'b1;
        slot_rank[slot]  = '0;
        fill_level       = fill_level + 1'b1;
      end else begin
        // At capacity: reuse the slot of the least recent entry.
        best = 0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_rank[i] >= best)) begin
            slot = i;
            best = slot_rank[i];
          end
        end
        if (slot < 0) begin
          slot          = 0;
          slot_valid[0] = 1'b1;
          slot_rank[0]  = '0;
          fill_level    = lkv_pkg::OCC_BITS'(1);
        end else begin
          promote(slot);
        end
      end
      slot_key[slot]   = req_key;
      slot_value[slot] = req_value;
    end
  endtask

  // Per-edge bookkeeping: reset, reply comparison, capacity writes, new requests.
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      fill_level = '0;
      cap_reg    = lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding: hit %0d, read_value %h",
                 hit, read_value);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
            fails++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   want.read_value, read_value);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = capacity;
      if (start && !busy) begin
        serve_request(cmd, key, write_value, want);
        expected_replies = {expected_replies, want};
      end
    end
    pending = expected_replies.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Drives gets and puts into the cache under a range of capacities and leaves
// prediction and comparison to the checker beside it.
module tb;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic                           cmd;
  logic [lkv_pkg::KEY_BITS-1:0]   key;
  logic [lkv_pkg::VALUE_BITS-1:0] write_value;
  logic                           done;
  logic                           hit;
  logic [lkv_pkg::VALUE_BITS-1:0] read_value;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [lkv_pkg::CAP_BITS-1:0]   capacity;
  int                             fail_count;
  int                             pending;

  lru_key_value_cache uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .key         (key),
    .write_value (write_value),
    .done        (done),
    .hit         (hit),
    .read_value  (read_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity)
  );

  lkv_checker reply_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .key         (key),
    .write_value (write_value),
    .done        (done),
    .hit         (hit),
    .read_value  (read_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Free-running clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Present one request and hold it until the cache takes it; start stays high.
  task automatic issue(input logic op, input logic [lkv_pkg::KEY_BITS-1:0] k,
                       input logic [lkv_pkg::VALUE_BITS-1:0] v);
    @(negedge clk);
    start       = 1'b1;
    cmd         = op;
    key         = k;
    write_value = v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Drop start and keep the request channel quiet for a span set by n.
  task automatic idle_for(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop issuing and wait until every reply has come back, plus a short margin.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the capacity register; only called once the cache has drained.
  task automatic set_capacity(input logic [lkv_pkg::CAP_BITS-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    capacity  = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic over a key pool a little larger than the capacity, so that
  // hits, updates and evictions all come up; a few keys are fresh noise.
  task automatic run_phase(input int n, input int cap, input int idle_pct);
    logic [lkv_pkg::KEY_BITS-1:0]   pool [0:31];
    logic [lkv_pkg::KEY_BITS-1:0]   k;
    logic [lkv_pkg::VALUE_BITS-1:0] v;
    logic                           op;
    int                             eff_cap;
    int                             pool_size;
    int                             pick;
    eff_cap = (cap == 0) ? 1 : ((cap > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : cap);
    pool_size = eff_cap + $urandom_range(1, 8);
    for (int i = 0; i < 32; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) pool[i] = '0;
      else if (pick == 1) pool[i] = '1;
      else pool[i] = $urandom;
    end
    for (int j = 0; j < n; j++) begin
      op = ($urandom_range(0, 1) == 1) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET;
      if ($urandom_range(0, 99) < 85) k = pool[5'($urandom_range(0, pool_size - 1))];
      else k = $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0) v = '0;
      else if (pick == 1) v = '1;
      else v = $urandom;
      issue(op, k, v);
      if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 14));
    end
  endtask

  // Main sequence: reset, directed requests, then random phases.
  initial begin : stimulus
    int caps [12];
    start       = 1'b0;
    cmd         = lkv_pkg::CMD_GET;
    key         = '0;
    write_value = '0;
    cfg_valid   = 1'b0;
    capacity    = '0;
    rst         = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty cache, extreme keys and values, put hit and get miss.
    issue(lkv_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    issue(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'h0000_0005, 32'h0000_0000);
    issue(lkv_pkg::CMD_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    issue(lkv_pkg::CMD_GET, 32'hA5A5_A5A5, 32'h0000_0000);
    drain();

    // Capacity zero behaves as one and sits below the present occupancy,
    // so each put miss evicts exactly one entry.
    set_capacity(5'd0);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0011);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0002, 32'h0000_0022);
    issue(lkv_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'h0000_0002, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // Capacity above the entry count saturates.
    set_capacity(5'd31);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0003, 32'h0000_0033);
    issue(lkv_pkg::CMD_PUT, 32'h0000_0004, 32'h0000_0044);
    issue(lkv_pkg::CMD_GET, 32'h0000_0002, 32'h0000_0000);
    issue(lkv_pkg::CMD_GET, 32'h0000_0003, 32'h0000_0000);

    // Random phases over a spread of capacities; the last one runs flat out.
    caps = '{16, 1, 5, 31, 2, 0, 8, 17, 16, 3, 12, 16};
    caps[10] = $urandom_range(0, 31);
    for (int p = 0; p < 12; p++) begin
      drain();
      set_capacity(caps[p][lkv_pkg::CAP_BITS-1:0]);
      run_phase(130, caps[p], (p == 11) ? 0 : $urandom_range(0, 50));
    end
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake or a missing reply.
  initial begin : watchdog
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
